// ===== rtl/core/gnc_pkg.sv =====
// Shared constants, codes and types of the greedy neighbour clustering block.
package gnc_pkg;

	// Table sizes
	localparam int MAX_VERTICES   = 4096;
	localparam int MAX_NEIGHBOURS = 16;

	// Field widths
	localparam int VTX_W    = $clog2(MAX_VERTICES);
	localparam int SLOT_W   = $clog2(MAX_NEIGHBOURS);
	localparam int NB_AW    = VTX_W + SLOT_W;
	localparam int VAL_W    = 16;
	localparam int GIDX_W   = 15;
	localparam int CNT_W    = 13;
	localparam int NN_W     = 5;
	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int REGIDX_W = 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] NV_MAX    = CNT_W'(MAX_VERTICES);
	localparam logic [NN_W-1:0]  NN_MAX    = NN_W'(MAX_NEIGHBOURS);

	// Operation codes of an input word
	localparam logic [OP_W-1:0] OP_LOAD_NB   = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_GLOB = 2'd1;
	localparam logic [OP_W-1:0] OP_SEED      = 2'd2;
	localparam logic [OP_W-1:0] OP_START     = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_SEED      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NEIGHBOUR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEGMENT   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REJECT    = 2'd3;

	// Register indexes
	localparam logic [REGIDX_W-1:0] REG_VERTEX_COUNT    = 1'd0;
	localparam logic [REGIDX_W-1:0] REG_NEIGHBOUR_COUNT = 1'd1;

	// Sequencer states
	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_CLEAR   = 9'b000000010,
		ST_SEED_RD = 9'b000000100,
		ST_SEED_EV = 9'b000001000,
		ST_NB_RD   = 9'b000010000,
		ST_NB_EV   = 9'b000100000,
		ST_NB_CHK  = 9'b001000000,
		ST_SEG     = 9'b010000000,
		ST_FLUSH   = 9'b100000000
	} state_t;

	// One result word
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VTX_W-1:0]  vtx;
		logic [GIDX_W-1:0] gidx;
		logic [CNT_W-1:0]  sel;
		logic              inv;
	} res_t;

endpackage

// ===== rtl/core/greedy_neighbour_clustering.sv =====
// Greedy neighbour clustering: table memories, used mask and seed sequencer.
//
// Usage. An input word is taken when start is high and busy is low; operation selects
// what it does. Load neighbour and load global index words write the neighbour table
// or the global index table and leave busy low. A start word clears the used mask
// with a sweep of one entry per cycle and zeroes the count. A seed word reads the
// mask and global index of the seed, then, unless the seed is rejected or already
// used, walks the neighbour slots one at a time through the neighbour memory and a
// read-modify-write of the used mask: a skipped slot passes the read and evaluate
// states, a checked neighbour also the check state. Each result word is held until
// the next one or the final flush releases it, so when no neighbour is associated
// the first result appears only at the end of the walk; results leave one per
// cycle at most, each marked by strobe for one cycle, the final one with last. The
// receiver cannot stall, so results are never held back by the receiver.
// Configuration is written through write_enable, register_index and write_data; the
// user must do so only while busy is low, the block does not enforce it. After reset
// the block runs the same mask clearing sweep, with busy high, before it takes a
// word; registers go to their reset values at once.
module greedy_neighbour_clustering (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [gnc_pkg::OP_W-1:0]            operation,
	input  logic [gnc_pkg::VTX_W-1:0]           vertex,
	input  logic [gnc_pkg::SLOT_W-1:0]          slot,
	input  logic signed [gnc_pkg::VAL_W-1:0]    value,
	input  logic                                single_assoc,
	input  logic                                segment_end,
	// configuration
	input  logic                                write_enable,
	input  logic [gnc_pkg::REGIDX_W-1:0]        register_index,
	input  logic [gnc_pkg::CNT_W-1:0]           write_data,
	// results
	output logic                                strobe,
	output logic [gnc_pkg::KIND_W-1:0]          kind,
	output logic [gnc_pkg::VTX_W-1:0]           vertex_out,
	output logic [gnc_pkg::GIDX_W-1:0]          global_index,
	output logic [gnc_pkg::CNT_W-1:0]           selection_number,
	output logic                                invalid,
	output logic                                last
);

	// Memories
	logic [gnc_pkg::VAL_W-1:0] nb_mem   [gnc_pkg::MAX_VERTICES*gnc_pkg::MAX_NEIGHBOURS];
	logic [gnc_pkg::VAL_W-1:0] glob_mem [gnc_pkg::MAX_VERTICES];
	logic                      mask_mem [gnc_pkg::MAX_VERTICES];

	logic [gnc_pkg::VAL_W-1:0] nb_rd_q;
	logic [gnc_pkg::VAL_W-1:0] glob_rd_q;
	logic                      mask_rd_q;

	// Control and working registers
	gnc_pkg::state_t            state_q;
	logic [gnc_pkg::VTX_W-1:0]  clr_q;
	logic [gnc_pkg::CNT_W-1:0]  count_q;
	logic [gnc_pkg::CNT_W-1:0]  vertex_count_q;
	logic [gnc_pkg::NN_W-1:0]   neighbour_count_q;
	logic [gnc_pkg::VTX_W-1:0]  vtx_q;
	logic [gnc_pkg::SLOT_W-1:0] slot_q;
	logic [gnc_pkg::VTX_W-1:0]  nb_q;
	logic                       below_q;
	logic                       seg_q;
	gnc_pkg::res_t              pend_q;
	logic                       pend_vld_q;
	gnc_pkg::res_t              out_q;
	logic                       strobe_q;
	logic                       last_q;

	// Combinational decisions
	logic                       accept;
	logic                       load_nb;
	logic                       load_glob;
	logic [gnc_pkg::CNT_W-1:0]  nv;
	logic [gnc_pkg::NN_W-1:0]   nn;
	logic                       seed_in_range;
	logic                       g_ok;
	logic                       nb_ok;
	logic                       last_slot;
	logic [gnc_pkg::CNT_W-1:0]  count_inc;
	logic [gnc_pkg::VTX_W-1:0]  tbl_ra;
	logic                       mask_we;
	logic [gnc_pkg::VTX_W-1:0]  mask_wa;
	logic                       mask_wd;
	logic                       push_en;
	gnc_pkg::res_t              push_res;
	logic                       walk_end;
	logic                       reject;

	assign busy      = (state_q != gnc_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign load_nb   = accept && (operation == gnc_pkg::OP_LOAD_NB);
	assign load_glob = accept && (operation == gnc_pkg::OP_LOAD_GLOB);

	// Effective limits
	assign nv = (vertex_count_q > gnc_pkg::NV_MAX) ? gnc_pkg::NV_MAX : vertex_count_q;
	assign nn = (neighbour_count_q > gnc_pkg::NN_MAX) ? gnc_pkg::NN_MAX : neighbour_count_q;

	// Range checks on the seed and on the registered memory data
	assign seed_in_range = ({1'b0, vtx_q} < nv);
	assign g_ok  = !glob_rd_q[gnc_pkg::VAL_W-1] &&
		(glob_rd_q[gnc_pkg::GIDX_W-1:0] < gnc_pkg::GIDX_W'(nv));
	assign nb_ok = !nb_rd_q[gnc_pkg::VAL_W-1] &&
		(nb_rd_q[gnc_pkg::GIDX_W-1:0] < gnc_pkg::GIDX_W'(nv));
	assign last_slot = ((gnc_pkg::NN_W'(slot_q) + gnc_pkg::NN_W'(1)) >= nn);
	assign count_inc = (count_q < gnc_pkg::COUNT_MAX) ? count_q + gnc_pkg::CNT_W'(1) : count_q;
	assign reject    = !seed_in_range || (!mask_rd_q && !g_ok);

	// Global table and mask are read at the seed, or at the neighbour just fetched
	assign tbl_ra = (state_q == gnc_pkg::ST_NB_EV) ? nb_rd_q[gnc_pkg::VTX_W-1:0] : vtx_q;

	// Neighbour table
	always_ff @(posedge clk) begin
		if (load_nb) begin
			nb_mem[{vertex, slot}] <= $unsigned(value);
		end
		nb_rd_q <= nb_mem[{vtx_q, slot_q}];
	end

	// Global index table
	always_ff @(posedge clk) begin
		if (load_glob) begin
			glob_mem[vertex] <= $unsigned(value);
		end
		glob_rd_q <= glob_mem[tbl_ra];
	end

	// Used mask
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[mask_wa] <= mask_wd;
		end
		mask_rd_q <= mask_mem[tbl_ra];
	end

	// Per-state result generation and mask writes
	always_comb begin
		push_en  = 1'b0;
		push_res = '0;
		mask_we  = 1'b0;
		mask_wa  = clr_q;
		mask_wd  = 1'b0;
		walk_end = 1'b0;
		unique case (state_q)
			gnc_pkg::ST_CLEAR: begin
				mask_we = 1'b1;
			end
			gnc_pkg::ST_SEED_EV: begin
				if (reject) begin
					push_en       = 1'b1;
					push_res.kind = gnc_pkg::KIND_REJECT;
					push_res.vtx  = vtx_q;
					push_res.sel  = count_q;
					push_res.inv  = 1'b1;
				end else if (!mask_rd_q) begin
					push_en       = 1'b1;
					push_res.kind = gnc_pkg::KIND_SEED;
					push_res.vtx  = vtx_q;
					push_res.gidx = glob_rd_q[gnc_pkg::GIDX_W-1:0];
					push_res.sel  = count_q;
					walk_end      = (nn == '0);
				end
			end
			gnc_pkg::ST_NB_EV: begin
				walk_end = !nb_ok && last_slot;
			end
			gnc_pkg::ST_NB_CHK: begin
				if (!mask_rd_q) begin
					mask_we       = 1'b1;
					mask_wa       = nb_q;
					mask_wd       = 1'b1;
					push_en       = 1'b1;
					push_res.kind = gnc_pkg::KIND_NEIGHBOUR;
					push_res.vtx  = nb_q;
					push_res.gidx = g_ok ? glob_rd_q[gnc_pkg::GIDX_W-1:0] : '0;
					push_res.sel  = count_q;
					push_res.inv  = !g_ok;
					walk_end      = below_q || last_slot;
				end else begin
					walk_end = last_slot;
				end
			end
			gnc_pkg::ST_SEG: begin
				push_en       = 1'b1;
				push_res.kind = gnc_pkg::KIND_SEGMENT;
				push_res.vtx  = vtx_q;
				push_res.sel  = count_q;
			end
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q    <= gnc_pkg::NV_MAX;
			neighbour_count_q <= gnc_pkg::NN_MAX;
		end else if (write_enable) begin
			unique case (register_index)
				gnc_pkg::REG_VERTEX_COUNT:    vertex_count_q    <= write_data;
				gnc_pkg::REG_NEIGHBOUR_COUNT: neighbour_count_q <= write_data[gnc_pkg::NN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, pending result word and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gnc_pkg::ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			vtx_q      <= '0;
			slot_q     <= '0;
			nb_q       <= '0;
			below_q    <= 1'b0;
			seg_q      <= 1'b0;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
			out_q      <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;

			// a new word pushes the held one out; last is known only at the flush
			if (push_en) begin
				if (pend_vld_q) begin
					out_q    <= pend_q;
					strobe_q <= 1'b1;
				end
				pend_q     <= push_res;
				pend_vld_q <= 1'b1;
			end

			if (walk_end) begin
				count_q <= count_inc;
			end

			unique case (state_q)
				gnc_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							gnc_pkg::OP_START: begin
								clr_q   <= '0;
								count_q <= '0;
								state_q <= gnc_pkg::ST_CLEAR;
							end
							gnc_pkg::OP_SEED: begin
								vtx_q      <= vertex;
								slot_q     <= '0;
								below_q    <= single_assoc;
								seg_q      <= segment_end;
								pend_vld_q <= 1'b0;
								state_q    <= gnc_pkg::ST_SEED_RD;
							end
							default: ;
						endcase
					end
				end
				gnc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + gnc_pkg::VTX_W'(1);
					if (clr_q == {gnc_pkg::VTX_W{1'b1}}) begin
						state_q <= gnc_pkg::ST_IDLE;
					end
				end
				gnc_pkg::ST_SEED_RD: begin
					state_q <= gnc_pkg::ST_SEED_EV;
				end
				gnc_pkg::ST_SEED_EV: begin
					if (reject || walk_end) begin
						state_q <= seg_q ? gnc_pkg::ST_SEG : gnc_pkg::ST_FLUSH;
					end else if (mask_rd_q) begin
						state_q <= seg_q ? gnc_pkg::ST_SEG : gnc_pkg::ST_IDLE;
					end else begin
						state_q <= gnc_pkg::ST_NB_RD;
					end
				end
				gnc_pkg::ST_NB_RD: begin
					state_q <= gnc_pkg::ST_NB_EV;
				end
				gnc_pkg::ST_NB_EV: begin
					if (walk_end) begin
						state_q <= seg_q ? gnc_pkg::ST_SEG : gnc_pkg::ST_FLUSH;
					end else if (!nb_ok) begin
						slot_q  <= slot_q + gnc_pkg::SLOT_W'(1);
						state_q <= gnc_pkg::ST_NB_RD;
					end else begin
						nb_q    <= nb_rd_q[gnc_pkg::VTX_W-1:0];
						state_q <= gnc_pkg::ST_NB_CHK;
					end
				end
				gnc_pkg::ST_NB_CHK: begin
					if (walk_end) begin
						state_q <= seg_q ? gnc_pkg::ST_SEG : gnc_pkg::ST_FLUSH;
					end else begin
						slot_q  <= slot_q + gnc_pkg::SLOT_W'(1);
						state_q <= gnc_pkg::ST_NB_RD;
					end
				end
				gnc_pkg::ST_SEG: begin
					state_q <= gnc_pkg::ST_FLUSH;
				end
				gnc_pkg::ST_FLUSH: begin
					out_q      <= pend_q;
					strobe_q   <= 1'b1;
					last_q     <= 1'b1;
					pend_vld_q <= 1'b0;
					state_q    <= gnc_pkg::ST_IDLE;
				end
				default: state_q <= gnc_pkg::ST_IDLE;
			endcase
		end
	end

	// Result ports
	assign strobe           = strobe_q;
	assign kind             = out_q.kind;
	assign vertex_out       = out_q.vtx;
	assign global_index     = out_q.gidx;
	assign selection_number = out_q.sel;
	assign invalid          = out_q.inv;
	assign last             = last_q;

	// A result word only ever leaves while an item is being worked on
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word without an item in progress");

	// The flush always has a held word to release
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gnc_pkg::ST_FLUSH) |-> pend_vld_q)
		else $error("flush with no held result word");

	// A start word always leads into the clearing sweep
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == gnc_pkg::OP_START)) |=> (state_q == gnc_pkg::ST_CLEAR))
		else $error("start word did not begin the mask sweep");

endmodule
